// ===== design/ascpu_pkg.sv =====
// ----------------------------------------------------------------------------
// ascpu_pkg
// Shared types, codes and the instruction classifier of the accumulator
// machine execute block.
// ----------------------------------------------------------------------------
package ascpu_pkg;

   localparam int unsigned MEM_BYTES_DEF = 65536;

   typedef enum logic [5:0] {
      OP_NOP = 6'd0,  OP_LDA = 6'd1,  OP_LDB = 6'd2,  OP_STA = 6'd3,
      OP_STB = 6'd4,  OP_LIA = 6'd5,  OP_SIA = 6'd6,  OP_LPC = 6'd7,
      OP_SPC = 6'd8,  OP_LYA = 6'd9,  OP_SYA = 6'd10, OP_JMP = 6'd11,
      OP_JZ  = 6'd12, OP_JNZ = 6'd13, OP_JN  = 6'd14, OP_JNN = 6'd15,
      OP_JE  = 6'd16, OP_JNE = 6'd17, OP_CAL = 6'd18, OP_RET = 6'd19,
      OP_PSH = 6'd20, OP_POP = 6'd21, OP_LSA = 6'd22, OP_SSA = 6'd23,
      OP_LSC = 6'd24, OP_SSC = 6'd25, OP_MOV = 6'd26, OP_NOT = 6'd27,
      OP_SHL = 6'd28, OP_SHR = 6'd29, OP_INC = 6'd30, OP_DEC = 6'd31,
      OP_NEG = 6'd32, OP_SWP = 6'd33, OP_AND = 6'd34, OP_OR  = 6'd35,
      OP_XOR = 6'd36, OP_ADD = 6'd37, OP_SUB = 6'd38, OP_PTU = 6'd39,
      OP_PTS = 6'd40, OP_PTB = 6'd41, OP_PTC = 6'd42, OP_GET = 6'd43,
      OP_GTC = 6'd44, OP_HLT = 6'd45
   } op_type;

   typedef enum logic [2:0] {
      ACC_NONE, ACC_RD_WORD, ACC_WR_WORD, ACC_RD_BYTE, ACC_WR_BYTE
   } acc_type;

   typedef enum logic [2:0] {
      AS_ARG, AS_B_ARG, AS_SP, AS_SP_M4, AS_SP_ARG
   } asrc_type;

   typedef enum logic [1:0] {LD_A, LD_B, LD_PC, LD_A_LOW} dest_type;

   typedef enum logic [1:0] {WS_A, WS_B, WS_PC} wsrc_type;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0, ERR_OOB = 3'd1, ERR_NO_STACK = 3'd2,
      ERR_UNDER = 3'd3, ERR_OVER = 3'd4, ERR_ALIGN = 3'd5
   } err_type;

   typedef enum logic [2:0] {
      PK_NONE = 3'd0, PK_UNSIGNED = 3'd1, PK_SIGNED = 3'd2,
      PK_BINARY = 3'd3, PK_CHAR = 3'd4
   } pkind_type;

   typedef enum logic [1:0] {
      CSR_BIG_ENDIAN = 2'd0, CSR_STACK_DEFINED = 2'd1,
      CSR_STACK_BEGIN = 2'd2, CSR_STACK_END = 2'd3
   } csr_type;

   typedef struct packed {
      op_type   op;
      acc_type  acc;
      logic     stack;
      asrc_type asrc;
      dest_type dest;
      wsrc_type wsrc;
   } dec_type;

   typedef struct packed {
      dec_type     dec;
      logic [31:0] arg;
      logic [31:0] ent;
   } item_type;

   function automatic dec_type decode(input logic [5:0] action);
      dec_type d;
      d.op    = op_type'(action);
      d.acc   = ACC_NONE;
      d.stack = 1'b0;
      d.asrc  = AS_ARG;
      d.dest  = LD_A;
      d.wsrc  = WS_A;
      case (action)
         OP_LDA: d.acc = ACC_RD_WORD;
         OP_LDB: begin
            d.acc  = ACC_RD_WORD;
            d.dest = LD_B;
         end
         OP_STA: d.acc = ACC_WR_WORD;
         OP_STB: begin
            d.acc  = ACC_WR_WORD;
            d.wsrc = WS_B;
         end
         OP_LIA: begin
            d.acc  = ACC_RD_WORD;
            d.asrc = AS_B_ARG;
         end
         OP_SIA: begin
            d.acc  = ACC_WR_WORD;
            d.asrc = AS_B_ARG;
         end
         OP_LYA: begin
            d.acc  = ACC_RD_BYTE;
            d.dest = LD_A_LOW;
         end
         OP_SYA: d.acc = ACC_WR_BYTE;
         OP_CAL: begin
            d.acc   = ACC_WR_WORD;
            d.stack = 1'b1;
            d.asrc  = AS_SP;
            d.wsrc  = WS_PC;
         end
         OP_RET: begin
            d.acc   = ACC_RD_WORD;
            d.stack = 1'b1;
            d.asrc  = AS_SP_M4;
            d.dest  = LD_PC;
         end
         OP_PSH: begin
            d.acc   = ACC_WR_WORD;
            d.stack = 1'b1;
            d.asrc  = AS_SP;
         end
         OP_POP: begin
            d.acc   = ACC_RD_WORD;
            d.stack = 1'b1;
            d.asrc  = AS_SP_M4;
         end
         OP_LSA: begin
            d.acc   = ACC_RD_WORD;
            d.stack = 1'b1;
            d.asrc  = AS_SP_ARG;
         end
         OP_SSA: begin
            d.acc   = ACC_WR_WORD;
            d.stack = 1'b1;
            d.asrc  = AS_SP_ARG;
         end
         default: ;
      endcase
      return d;
   endfunction

endpackage

// ===== design/ascpu_ram.sv =====
// ----------------------------------------------------------------------------
// ascpu_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ascpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ascpu_front.sv =====
// ----------------------------------------------------------------------------
// ascpu_front
// Accepts instruction items, classifies them and holds them in a two-entry
// queue for the execute unit.
// ----------------------------------------------------------------------------
module ascpu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [5:0]          req_action,
   input  logic [31:0]         req_argument,
   input  logic [31:0]         req_entered_value,
   input  logic                hold,
   output logic                q_valid,
   output ascpu_pkg::item_type q_item,
   input  logic                q_pop
);
   import ascpu_pkg::*;

   item_type   fifo_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       push;

   assign req_ready = !hold && (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = fifo_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= '{dec: decode(req_action), arg: req_argument,
                                 ent: req_entered_value};
      end
   end

endmodule

// ===== design/ascpu_back.sv =====
// ----------------------------------------------------------------------------
// ascpu_back
// Execute unit: architectural registers, banked byte memory with its clear
// pass, and the result register.
// ----------------------------------------------------------------------------
module ascpu_back #(
   parameter int unsigned MEM_BYTES = ascpu_pkg::MEM_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [16:0]         csr_wdata,
   input  logic                q_valid,
   input  ascpu_pkg::item_type q_item,
   output logic                q_pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_acc_a,
   output logic [31:0]         rsp_acc_b,
   output logic [31:0]         rsp_next_pc,
   output logic [31:0]         rsp_stack_pointer,
   output logic                rsp_is_zero,
   output logic                rsp_is_negative,
   output logic                rsp_is_even,
   output logic [2:0]          rsp_print_kind,
   output logic                rsp_halted,
   output logic [2:0]          rsp_error_code,
   output logic                rsp_error_seen
);
   import ascpu_pkg::*;

   localparam int unsigned ROWS = (MEM_BYTES + 3) / 4;
   localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_ISSUE  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [RAW-1:0] clr_cnt_ff;

   // configuration
   logic        big_endian_ff, stack_defined_ff;
   logic [16:0] stack_begin_ff, stack_end_ff;

   // architectural state
   logic [31:0] a_ff, b_ff, pc_ff, sp_ff;
   logic        z_ff, n_ff, e_ff, seen_ff;

   // issue to finish
   logic [31:0] p_a_ff, p_b_ff, p_pc_ff, p_sp_ff;
   logic        p_load_ff, p_byte_ff, p_stfail_ff, p_halt_ff;
   dest_type    p_dest_ff;
   err_type     p_err_ff;
   pkind_type   p_kind_ff;
   logic [3:0]  rd_ok_ff;
   logic [1:0]  m_lo_ff;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_a_ff, rsp_b_ff, rsp_pc_ff, rsp_sp_ff;
   logic        rsp_z_ff, rsp_n_ff, rsp_e_ff, rsp_halt_ff, rsp_seen_ff;
   logic [2:0]  rsp_kind_ff, rsp_err_ff;

   // memory banks
   logic [3:0]     ram_we, ram_re;
   logic [RAW-1:0] ram_row   [4];
   logic [7:0]     ram_wdata [4];
   logic [7:0]     ram_rdata [4];

   logic issue, finish;

   // issue-side values
   dec_type     dec;
   logic [31:0] m;
   logic [31:0] pc5;
   err_type     st_err;
   logic        access, is_word, is_write, oob;
   logic [3:0]  ok;
   logic [31:0] a_n, b_n, pc_n, sp_n, wword;
   err_type     err_n;
   pkind_type   kind_n;

   // finish-side values
   logic [31:0] ld_word, a_f, b_f, pc_f;
   logic [7:0]  ld_byte;
   err_type     err_f;

   assign issue    = (state_ff == ST_ISSUE) && q_valid;
   assign finish   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign q_pop    = issue;
   assign clearing = (state_ff == ST_CLEAR);
   assign dec      = q_item.dec;
   assign pc5      = pc_ff + 32'd5;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_cnt_ff == RAW'(ROWS - 1)) state_in = ST_ISSUE;
         ST_ISSUE:  if (issue) state_in = ST_FINISH;
         ST_FINISH: if (finish) state_in = ST_ISSUE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // address, stack check and bank control
   always_comb begin
      logic [1:0]  idx;
      logic [1:0]  lane;
      logic [31:0] baddr;
      case (dec.asrc)
         AS_B_ARG:  m = b_ff + q_item.arg;
         AS_SP:     m = sp_ff;
         AS_SP_M4:  m = sp_ff - 32'd4;
         AS_SP_ARG: m = sp_ff + q_item.arg;
         default:   m = q_item.arg;
      endcase

      if (!stack_defined_ff) begin
         st_err = ERR_NO_STACK;
      end else if (m < {15'd0, stack_begin_ff}) begin
         st_err = ERR_UNDER;
      end else if (m >= {15'd0, stack_end_ff}) begin
         st_err = ERR_OVER;
      end else if (m[1:0] != stack_begin_ff[1:0]) begin
         st_err = ERR_ALIGN;
      end else begin
         st_err = ERR_NONE;
      end

      case (dec.wsrc)
         WS_B:    wword = b_ff;
         WS_PC:   wword = pc5;
         default: wword = a_ff;
      endcase

      access   = issue && (dec.acc != ACC_NONE) && !(dec.stack && (st_err != ERR_NONE));
      is_word  = (dec.acc == ACC_RD_WORD) || (dec.acc == ACC_WR_WORD);
      is_write = (dec.acc == ACC_WR_WORD) || (dec.acc == ACC_WR_BYTE);
      oob      = 1'b0;

      for (int k = 0; k < 4; k++) begin
         idx   = 2'(k) - m[1:0];
         baddr = m + {30'd0, idx};
         ok[k] = (is_word || idx == 2'd0) && (baddr < 32'(MEM_BYTES));
         if ((is_word || idx == 2'd0) && !(baddr < 32'(MEM_BYTES))) begin
            oob = access;
         end
         lane = !is_word ? 2'd0 : (big_endian_ff ? ~idx : idx);
         if (clearing) begin
            ram_we[k]    = 1'b1;
            ram_re[k]    = 1'b0;
            ram_row[k]   = clr_cnt_ff;
            ram_wdata[k] = 8'd0;
         end else begin
            ram_we[k]    = access && is_write && ok[k];
            ram_re[k]    = access && !is_write && ok[k];
            ram_row[k]   = baddr[RAW+1:2];
            ram_wdata[k] = 8'(wword >> {lane, 3'b000});
         end
      end
   end

   // register moves that do not wait for memory
   always_comb begin
      a_n    = a_ff;
      b_n    = b_ff;
      pc_n   = pc5;
      sp_n   = sp_ff;
      kind_n = PK_NONE;
      case (dec.op)
         OP_LPC: pc_n = a_ff;
         OP_SPC: a_n = pc5;
         OP_JMP: pc_n = q_item.arg;
         OP_JZ:  if (z_ff) pc_n = q_item.arg;
         OP_JNZ: if (!z_ff) pc_n = q_item.arg;
         OP_JN:  if (n_ff) pc_n = q_item.arg;
         OP_JNN: if (!n_ff) pc_n = q_item.arg;
         OP_JE:  if (e_ff) pc_n = q_item.arg;
         OP_JNE: if (!e_ff) pc_n = q_item.arg;
         OP_CAL: begin
            sp_n = sp_ff + 32'd4;
            pc_n = q_item.arg;
         end
         OP_RET: sp_n = sp_ff - 32'd4;
         OP_PSH: sp_n = sp_ff + 32'd4;
         OP_POP: sp_n = sp_ff - 32'd4;
         OP_LSC: sp_n = a_ff;
         OP_SSC: a_n = sp_ff;
         OP_MOV: a_n = q_item.arg;
         OP_NOT: a_n = ~a_ff;
         OP_SHL: a_n = (q_item.arg[7:5] != 3'd0) ? 32'd0 : (a_ff << q_item.arg[4:0]);
         OP_SHR: a_n = (q_item.arg[7:5] != 3'd0) ? 32'd0 : (a_ff >> q_item.arg[4:0]);
         OP_INC: a_n = a_ff + q_item.arg;
         OP_DEC: a_n = a_ff - q_item.arg;
         OP_NEG: a_n = 32'd0 - a_ff;
         OP_SWP: begin
            a_n = b_ff;
            b_n = a_ff;
         end
         OP_AND: a_n = a_ff & b_ff;
         OP_OR:  a_n = a_ff | b_ff;
         OP_XOR: a_n = a_ff ^ b_ff;
         OP_ADD: a_n = a_ff + b_ff;
         OP_SUB: a_n = a_ff - b_ff;
         OP_PTU: kind_n = PK_UNSIGNED;
         OP_PTS: kind_n = PK_SIGNED;
         OP_PTB: kind_n = PK_BINARY;
         OP_PTC: kind_n = PK_CHAR;
         OP_GET: a_n = q_item.ent;
         OP_GTC: a_n = q_item.ent;
         default: ;
      endcase

      if (dec.stack && (dec.acc != ACC_NONE) && (st_err != ERR_NONE)) begin
         err_n = st_err;
      end else if (oob) begin
         err_n = ERR_OOB;
      end else begin
         err_n = ERR_NONE;
      end
   end

   // load data assembly and write-back
   always_comb begin
      logic [1:0] k;
      logic [1:0] lane;
      ld_word = 32'd0;
      for (int i = 0; i < 4; i++) begin
         k    = m_lo_ff + 2'(i);
         lane = big_endian_ff ? ~2'(i) : 2'(i);
         if (rd_ok_ff[k]) begin
            ld_word = ld_word | (32'(ram_rdata[k]) << {lane, 3'b000});
         end
      end
      ld_byte = rd_ok_ff[m_lo_ff] ? ram_rdata[m_lo_ff] : 8'd0;
      if (p_stfail_ff) begin
         ld_word = 32'd0;
      end

      a_f  = p_a_ff;
      b_f  = p_b_ff;
      pc_f = p_pc_ff;
      if (p_load_ff) begin
         case (p_dest_ff)
            LD_B:     b_f = ld_word;
            LD_PC:    pc_f = ld_word;
            LD_A_LOW: a_f = {p_a_ff[31:8], ld_byte};
            default:  a_f = ld_word;
         endcase
      end
      err_f = p_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_cnt_ff       <= '0;
         big_endian_ff    <= 1'b0;
         stack_defined_ff <= 1'b0;
         stack_begin_ff   <= 17'd0;
         stack_end_ff     <= 17'd0;
         a_ff             <= 32'd0;
         b_ff             <= 32'd0;
         pc_ff            <= 32'd0;
         sp_ff            <= 32'd0;
         z_ff             <= 1'b1;
         n_ff             <= 1'b0;
         e_ff             <= 1'b1;
         seen_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clr_cnt_ff <= clr_cnt_ff + RAW'(1);
         end
         if (finish) begin
            a_ff         <= a_f;
            b_ff         <= b_f;
            pc_ff        <= pc_f;
            sp_ff        <= p_sp_ff;
            z_ff         <= (a_f == 32'd0);
            n_ff         <= a_f[31];
            e_ff         <= !a_f[0];
            seen_ff      <= seen_ff || (err_f != ERR_NONE);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_BIG_ENDIAN:    big_endian_ff <= csr_wdata[0];
               CSR_STACK_DEFINED: stack_defined_ff <= csr_wdata[0];
               CSR_STACK_BEGIN: begin
                  stack_begin_ff <= csr_wdata;
                  sp_ff          <= {15'd0, csr_wdata};
               end
               CSR_STACK_END:     stack_end_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p_a_ff      <= a_n;
         p_b_ff      <= b_n;
         p_pc_ff     <= pc_n;
         p_sp_ff     <= sp_n;
         p_load_ff   <= (dec.acc == ACC_RD_WORD) || (dec.acc == ACC_RD_BYTE);
         p_byte_ff   <= (dec.acc == ACC_RD_BYTE);
         p_stfail_ff <= dec.stack && (st_err != ERR_NONE);
         p_halt_ff   <= (dec.op == OP_HLT);
         p_dest_ff   <= dec.dest;
         p_err_ff    <= err_n;
         p_kind_ff   <= kind_n;
         rd_ok_ff    <= access ? ok : 4'd0;
         m_lo_ff     <= m[1:0];
      end
      if (finish) begin
         rsp_a_ff    <= a_f;
         rsp_b_ff    <= b_f;
         rsp_pc_ff   <= pc_f;
         rsp_sp_ff   <= p_sp_ff;
         rsp_z_ff    <= (a_f == 32'd0);
         rsp_n_ff    <= a_f[31];
         rsp_e_ff    <= !a_f[0];
         rsp_kind_ff <= p_kind_ff;
         rsp_halt_ff <= p_halt_ff && !p_byte_ff;
         rsp_err_ff  <= err_f;
         rsp_seen_ff <= seen_ff || (err_f != ERR_NONE);
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      ascpu_ram #(
         .WIDTH (8),
         .DEPTH (ROWS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (ram_we[g]),
         .wr_addr (ram_row[g]),
         .wr_data (ram_wdata[g]),
         .rd_en   (ram_re[g]),
         .rd_addr (ram_row[g]),
         .rd_data (ram_rdata[g])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_acc_a         = rsp_a_ff;
   assign rsp_acc_b         = rsp_b_ff;
   assign rsp_next_pc       = rsp_pc_ff;
   assign rsp_stack_pointer = rsp_sp_ff;
   assign rsp_is_zero       = rsp_z_ff;
   assign rsp_is_negative   = rsp_n_ff;
   assign rsp_is_even       = rsp_e_ff;
   assign rsp_print_kind    = rsp_kind_ff;
   assign rsp_halted        = rsp_halt_ff;
   assign rsp_error_code    = rsp_err_ff;
   assign rsp_error_seen    = rsp_seen_ff;

endmodule

// ===== design/accumulator_stack_cpu_execute.sv =====
// ----------------------------------------------------------------------------
// accumulator_stack_cpu_execute
// Execute stage of a 32-bit accumulator machine with byte data memory.
// ----------------------------------------------------------------------------
// The req channel takes one decoded instruction per item (action, argument,
// entered_value); the rsp channel returns one item with the registers, flags,
// print kind, halt and error status after that instruction. Both channels are
// valid/ready. The user must write byte order and stack bounds over the csr
// port only while idle; the block itself does not enforce this. A front
// queue of two entries classifies and buffers items, so req keeps moving
// while a result waits on rsp. The execute unit handles each item in an
// issue state, which forms the address and accesses the four byte banks,
// then a finish state, which merges the registered read data and writes
// back the registers; it takes no new item until the last has finished.
// After reset the memory is cleared one row of four bytes per cycle, and
// req_ready stays low during the pass. When rsp stalls, the result holds,
// the queue fills and then req_ready drops.
// ----------------------------------------------------------------------------
module accumulator_stack_cpu_execute #(
   parameter int unsigned MEM_BYTES = ascpu_pkg::MEM_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_action,
   input  logic [31:0] req_argument,
   input  logic [31:0] req_entered_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_acc_a,
   output logic [31:0] rsp_acc_b,
   output logic [31:0] rsp_next_pc,
   output logic [31:0] rsp_stack_pointer,
   output logic        rsp_is_zero,
   output logic        rsp_is_negative,
   output logic        rsp_is_even,
   output logic [2:0]  rsp_print_kind,
   output logic        rsp_halted,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_error_seen,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   import ascpu_pkg::*;

   logic     q_valid;
   logic     q_pop;
   logic     clearing;
   item_type q_item;

   ascpu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_argument      (req_argument),
      .req_entered_value (req_entered_value),
      .hold              (clearing),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   ascpu_back #(
      .MEM_BYTES (MEM_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_acc_a         (rsp_acc_a),
      .rsp_acc_b         (rsp_acc_b),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_stack_pointer (rsp_stack_pointer),
      .rsp_is_zero       (rsp_is_zero),
      .rsp_is_negative   (rsp_is_negative),
      .rsp_is_even       (rsp_is_even),
      .rsp_print_kind    (rsp_print_kind),
      .rsp_halted        (rsp_halted),
      .rsp_error_code    (rsp_error_code),
      .rsp_error_seen    (rsp_error_seen)
   );

endmodule

// ===== design/ascpu_checker.sv =====
// ----------------------------------------------------------------------------
// ascpu_checker
// Port-level checks of the execute block's result channel.
// ----------------------------------------------------------------------------
module ascpu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_acc_a,
   input logic        rsp_is_zero,
   input logic        rsp_is_negative,
   input logic        rsp_is_even,
   input logic [2:0]  rsp_print_kind,
   input logic        rsp_halted,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_error_seen
);
   import ascpu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_acc_a))
      else $error("rsp item changed while stalled");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_zero == (rsp_acc_a == 32'd0))
                 && (rsp_is_negative == rsp_acc_a[31])
                 && (rsp_is_even == !rsp_acc_a[0]))
      else $error("flags disagree with A");

   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) |-> rsp_error_seen)
      else $error("error reported without sticky flag");

   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |-> (rsp_print_kind == PK_NONE)
                                  && (rsp_error_code == ERR_NONE))
      else $error("halt item carries print or error");

endmodule

bind accumulator_stack_cpu_execute ascpu_checker u_ascpu_checker (.*);

// ===== sim/accumulator_stack_cpu_execute_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accumulator_stack_cpu_execute_checker
// Watches the req, rsp and csr ports of the execute block, keeps its own
// machine state and byte memory, predicts the result of every accepted
// instruction and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module accumulator_stack_cpu_execute_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [5:0]  req_action,
   input  logic [31:0] req_argument,
   input  logic [31:0] req_entered_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_acc_a,
   input  logic [31:0] rsp_acc_b,
   input  logic [31:0] rsp_next_pc,
   input  logic [31:0] rsp_stack_pointer,
   input  logic        rsp_is_zero,
   input  logic        rsp_is_negative,
   input  logic        rsp_is_even,
   input  logic [2:0]  rsp_print_kind,
   input  logic        rsp_halted,
   input  logic [2:0]  rsp_error_code,
   input  logic        rsp_error_seen,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count,
   output int          error_result_count
);
   import ascpu_pkg::*;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] pc;
      logic [31:0] sp;
      logic        zf;
      logic        nf;
      logic        ef;
      logic [2:0]  kind;
      logic        halt;
      logic [2:0]  err;
      logic        seen;
   } result_type;

   logic [7:0]  mem [MEM_BYTES_DEF];
   logic [31:0] reg_a, reg_b, reg_pc, reg_sp;
   logic        flag_z, flag_n, flag_e, err_latch;
   logic        big_end, stk_def;
   logic [16:0] stk_lo, stk_hi;
   logic [2:0]  step_err;
   result_type  expected_results[$];

   function automatic void flag_error(input err_type code);
      if (step_err == ERR_NONE) step_err = code;
      err_latch = 1'b1;
   endfunction

   function automatic logic [7:0] mem_rd8(input logic [31:0] addr);
      if (addr >= MEM_BYTES_DEF) begin
         flag_error(ERR_OOB);
         return 8'h00;
      end
      return mem[addr];
   endfunction

   function automatic void mem_wr8(input logic [31:0] addr, input logic [7:0] v);
      if (addr >= MEM_BYTES_DEF) flag_error(ERR_OOB);
      else mem[addr] = v;
   endfunction

   function automatic logic [31:0] mem_rd32(input logic [31:0] addr);
      logic [31:0] w;
      w = '0;
      for (int i = 0; i < 4; i++)
         w |= 32'(mem_rd8(addr + i)) << (big_end ? 24 - 8 * i : 8 * i);
      return w;
   endfunction

   function automatic void mem_wr32(input logic [31:0] addr, input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         mem_wr8(addr + i, 8'(w >> (big_end ? 24 - 8 * i : 8 * i)));
   endfunction

   function automatic bit stack_check(input logic [31:0] addr);
      if (!stk_def) flag_error(ERR_NO_STACK);
      else if (addr < 32'(stk_lo)) flag_error(ERR_UNDER);
      else if (addr >= 32'(stk_hi)) flag_error(ERR_OVER);
      else if (((addr - 32'(stk_lo)) & 32'd3) != 0) flag_error(ERR_ALIGN);
      else return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [31:0] stack_rd(input logic [31:0] addr);
      return stack_check(addr) ? mem_rd32(addr) : 32'd0;
   endfunction

   function automatic void stack_wr(input logic [31:0] addr, input logic [31:0] w);
      if (stack_check(addr)) mem_wr32(addr, w);
   endfunction

   function automatic result_type execute_instr(input logic [5:0] act,
                                                input logic [31:0] arg,
                                                input logic [31:0] ent);
      result_type r;
      logic [31:0] a, b, pc, sp, t;
      logic [2:0]  kind;
      logic        halt;
      a = reg_a; b = reg_b; pc = reg_pc + 32'd5; sp = reg_sp;
      kind = PK_NONE; halt = 1'b0; step_err = ERR_NONE;
      case (act)
         OP_LDA: a = mem_rd32(arg);
         OP_LDB: b = mem_rd32(arg);
         OP_STA: mem_wr32(arg, a);
         OP_STB: mem_wr32(arg, b);
         OP_LIA: a = mem_rd32(b + arg);
         OP_SIA: mem_wr32(b + arg, a);
         OP_LPC: pc = a;
         OP_SPC: a = pc;
         OP_LYA: a = {a[31:8], mem_rd8(arg)};
         OP_SYA: mem_wr8(arg, a[7:0]);
         OP_JMP: pc = arg;
         OP_JZ:  if (flag_z) pc = arg;
         OP_JNZ: if (!flag_z) pc = arg;
         OP_JN:  if (flag_n) pc = arg;
         OP_JNN: if (!flag_n) pc = arg;
         OP_JE:  if (flag_e) pc = arg;
         OP_JNE: if (!flag_e) pc = arg;
         OP_CAL: begin
            stack_wr(sp, pc);
            sp += 4;
            pc = arg;
         end
         OP_RET: begin
            sp -= 4;
            pc = stack_rd(sp);
         end
         OP_PSH: begin
            stack_wr(sp, a);
            sp += 4;
         end
         OP_POP: begin
            sp -= 4;
            a = stack_rd(sp);
         end
         OP_LSA: a = stack_rd(sp + arg);
         OP_SSA: stack_wr(sp + arg, a);
         OP_LSC: sp = a;
         OP_SSC: a = sp;
         OP_MOV: a = arg;
         OP_NOT: a = ~a;
         OP_SHL: a = (arg[7:0] >= 32) ? 32'd0 : a << arg[7:0];
         OP_SHR: a = (arg[7:0] >= 32) ? 32'd0 : a >> arg[7:0];
         OP_INC: a = a + arg;
         OP_DEC: a = a - arg;
         OP_NEG: a = -a;
         OP_SWP: begin
            t = a;
            a = b;
            b = t;
         end
         OP_AND: a &= b;
         OP_OR:  a |= b;
         OP_XOR: a ^= b;
         OP_ADD: a = a + b;
         OP_SUB: a = a - b;
         OP_PTU: kind = PK_UNSIGNED;
         OP_PTS: kind = PK_SIGNED;
         OP_PTB: kind = PK_BINARY;
         OP_PTC: kind = PK_CHAR;
         OP_GET, OP_GTC: a = ent;
         OP_HLT: halt = 1'b1;
         default: ;
      endcase
      reg_a = a; reg_b = b; reg_pc = pc; reg_sp = sp;
      flag_z = (a == 0); flag_n = a[31]; flag_e = !a[0];
      r = '{a, b, pc, sp, flag_z, flag_n, flag_e, kind, halt, step_err, err_latch};
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         foreach (mem[i]) mem[i] = 8'h00;
         reg_a = 0; reg_b = 0; reg_pc = 0; reg_sp = 0;
         flag_z = 1; flag_n = 0; flag_e = 1; err_latch = 0;
         big_end = 0; stk_def = 0; stk_lo = 0; stk_hi = 0;
         expected_results.delete();
         fail_count = 0; result_count = 0; error_result_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_BIG_ENDIAN:    big_end = csr_wdata[0];
               CSR_STACK_DEFINED: stk_def = csr_wdata[0];
               CSR_STACK_BEGIN: begin
                  stk_lo = csr_wdata;
                  reg_sp = 32'(csr_wdata);
               end
               CSR_STACK_END:     stk_hi = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_results.insert(expected_results.size(),
                                    execute_instr(req_action, req_argument,
                                                  req_entered_value));
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (rsp_error_code != ERR_NONE) error_result_count++;
            if (expected_results.size() == 0) begin
               $display("%0t: result item with no expectation waiting", $time);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               compare_field("acc_a", e.a, rsp_acc_a);
               compare_field("acc_b", e.b, rsp_acc_b);
               compare_field("next_pc", e.pc, rsp_next_pc);
               compare_field("stack_pointer", e.sp, rsp_stack_pointer);
               compare_field("is_zero", e.zf, rsp_is_zero);
               compare_field("is_negative", e.nf, rsp_is_negative);
               compare_field("is_even", e.ef, rsp_is_even);
               compare_field("print_kind", e.kind, rsp_print_kind);
               compare_field("halted", e.halt, rsp_halted);
               compare_field("error_code", e.err, rsp_error_code);
               compare_field("error_seen", e.seen, rsp_error_seen);
            end
         end
      end
   end

endmodule

// ===== sim/tb_accumulator_stack_cpu_execute.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accumulator_stack_cpu_execute
// Drives decoded instructions into the execute block under random gaps and
// stalls across several byte-order and stack-bound settings; the checker
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_accumulator_stack_cpu_execute;
   import ascpu_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [5:0]  req_action;
   logic [31:0] req_argument, req_entered_value;
   logic        rsp_valid, rsp_ready;
   logic [31:0] rsp_acc_a, rsp_acc_b, rsp_next_pc, rsp_stack_pointer;
   logic        rsp_is_zero, rsp_is_negative, rsp_is_even, rsp_halted, rsp_error_seen;
   logic [2:0]  rsp_print_kind, rsp_error_code;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [16:0] csr_wdata;
   int          fail_count, pending_count, result_count, error_result_count;
   int          cycle_count = 0;
   int          item_count;
   logic [16:0] stk_lo;
   bit          hold_rsp;

   accumulator_stack_cpu_execute dut (.*);
   accumulator_stack_cpu_execute_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stall per item, plus long hold-offs on request
   initial begin
      int gap;
      rsp_ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (60) @(posedge clock);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         if ($urandom_range(0, 1)) gap = 0;
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock iff rsp_valid);
      end
   end

   // valid stays up after acceptance so back-to-back items see no bubble
   task automatic send_item(input logic [5:0] act, input logic [31:0] arg,
                            input logic [31:0] ent, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 19);
      if (!no_gap && $urandom_range(0, 1)) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1;
      req_action        <= act;
      req_argument      <= arg;
      req_entered_value <= ent;
      @(posedge clock iff req_ready);
      item_count++;
   endtask

   task automatic drain_results();
      req_valid <= 0;
      @(posedge clock iff pending_count == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input csr_type idx, input logic [16:0] v);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // addresses mostly inside memory, some straddling the end, some far off
   function automatic logic [31:0] rand_addr();
      case ($urandom_range(0, 7))
         0: return 32'h0000_fffc + $urandom_range(0, 3);
         1: return $urandom;
         2: return 32'hffff_fffe;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic logic [31:0] rand_arg(input logic [5:0] act);
      case (act)
         OP_LSA, OP_SSA: return $urandom_range(0, 3) == 0 ?
                                32'($urandom_range(0, 40)) - 32'd20 : 32'(4 * $urandom_range(0, 7)) - 32'd12;
         OP_SHL, OP_SHR: return {$urandom_range(0, 3) == 0 ? 24'($urandom) : 24'd0,
                                 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 33))};
         OP_JMP, OP_JZ, OP_JNZ, OP_JN, OP_JNN, OP_JE, OP_JNE, OP_CAL, OP_INC,
         OP_DEC, OP_MOV: return rand_word();
         default: return rand_addr();
      endcase
   endfunction

   task automatic random_phase(input int n);
      logic [5:0] act;
      logic [31:0] a0;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: act = 6'($urandom_range(46, 63));
            1, 2: act = 6'($urandom_range(OP_CAL, OP_SSC));
            3: begin
               // call and return pair
               send_item(OP_CAL, rand_word(), 0, 0);
               act = OP_RET;
            end
            default: act = 6'($urandom_range(OP_NOP, OP_HLT));
         endcase
         // LSC with a random A would wreck the stack: load A with a near stack address
         if (act == OP_LSC && $urandom_range(0, 3) != 0) begin
            a0 = 32'(stk_lo) + 4 * $urandom_range(0, 6) + ($urandom_range(0, 4) == 0);
            send_item(OP_MOV, a0, 0, 0);
         end
         send_item(act, rand_arg(act), rand_word(), i % 200 < 40);
      end
   endtask

   task automatic set_stack(input bit be, input bit def,
                            input logic [16:0] lo, input logic [16:0] hi);
      drain_results();
      stk_lo = lo;
      write_csr(CSR_BIG_ENDIAN, be);
      write_csr(CSR_STACK_DEFINED, def);
      write_csr(CSR_STACK_BEGIN, lo);
      write_csr(CSR_STACK_END, hi);
      csr_write <= 0;
   endtask

   initial begin
      reset = 1; req_valid = 0; req_action = 0; req_argument = 0;
      req_entered_value = 0; csr_write = 0; csr_index = 0; csr_wdata = 0;
      item_count = 0; hold_rsp = 0; stk_lo = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: no stack, then extremes and every operation
      send_item(OP_PSH, 0, 0, 0);
      send_item(OP_HLT, 0, 0, 0);
      send_item(OP_MOV, 32'hffff_ffff, 0, 0);
      send_item(OP_STA, 32'h0000_fffe, 0, 0);
      send_item(OP_LDB, 32'h0000_fffc, 0, 0);
      send_item(OP_SHL, 32'h0000_0020, 0, 0);
      send_item(OP_GET, 0, 32'h8000_0001, 0);
      send_item(OP_SHR, 32'hffff_ff1f, 0, 0);
      send_item(OP_LYA, 32'hffff_ffff, 0, 0);
      send_item(6'd63, 32'hffff_ffff, 32'hffff_ffff, 0);
      set_stack(1, 1, 17'd256, 17'd272);
      send_item(OP_MOV, 32'h1234_5678, 0, 0);
      send_item(OP_PSH, 0, 0, 0);
      send_item(OP_LDA, 32'd256, 0, 0);
      send_item(OP_POP, 0, 0, 0);
      send_item(OP_POP, 0, 0, 0);
      send_item(OP_LSA, 32'd2, 0, 0);
      send_item(OP_SSA, 32'd64, 0, 0);
      for (int op = OP_NOP; op <= OP_HLT; op++)
         send_item(6'(op), rand_arg(6'(op)), rand_word(), 0);

      set_stack(0, 1, 17'd0, 17'd64);
      random_phase(300);
      // receiver holds off for long stretches while items keep coming
      hold_rsp = 1;
      random_phase(20);
      hold_rsp = 0;
      set_stack(1, 1, 17'd1000, 17'd1040);
      random_phase(300);
      set_stack(0, 1, 17'h0fff0, 17'h10000);
      random_phase(250);
      set_stack(1, 0, 17'd64, 17'd128);
      random_phase(150);
      set_stack(0, 1, 17'h10000, 17'h1ffff);
      random_phase(150);
      set_stack(1, 1, 17'd0, 17'd0);
      random_phase(100);
      set_stack(0, 1, 17'd500, 17'd530);
      random_phase(150);

      drain_results();
      $display("Sent %0d instructions, checked %0d results (%0d with an error code)",
               item_count, result_count, error_result_count);
      $display("across eight byte-order and stack-bound settings");
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== accumulator_stack_cpu_execute.f =====
design/ascpu_pkg.sv
design/ascpu_ram.sv
design/ascpu_front.sv
design/ascpu_back.sv
design/accumulator_stack_cpu_execute.sv
design/ascpu_checker.sv
sim/accumulator_stack_cpu_execute_checker.sv
sim/tb_accumulator_stack_cpu_execute.sv
